// ===== design/psfbt_pkg.sv =====
//------------------------------------------------------------------------------
// psfbt_pkg: shared types and constants for the per-source flood ban table
// Register indexes, command codes, defaults and the entry record type.
//------------------------------------------------------------------------------
package psfbt_pkg;

	localparam int TableEntriesDefault = 64;
	localparam int SweepPerTickDefault = 1;

	localparam logic [1:0] CMD_CHECK  = 2'd0;
	localparam logic [1:0] CMD_TICKET = 2'd1;
	localparam logic [1:0] CMD_REPORT = 2'd2;
	localparam logic [1:0] CMD_TICK   = 2'd3;

	localparam logic [1:0] REG_FORGET = 2'd0;
	localparam logic [1:0] REG_RESET  = 2'd1;
	localparam logic [1:0] REG_MAX    = 2'd2;
	localparam logic [1:0] REG_BAN    = 2'd3;

	// entry update unit operations
	localparam logic [1:0] OP_ADD     = 2'd0;
	localparam logic [1:0] OP_REFRESH = 2'd1;
	localparam logic [1:0] OP_FORGET  = 2'd2;

	// one table entry, kept as a single memory word
	typedef struct packed {
		logic [31:0] addr;
		logic [31:0] tickets;
		logic [31:0] last_seen;
		logic [31:0] last_reset;
		logic [31:0] ban_until;
		logic [15:0] bans;
	} entry_t;

	// saturating unsigned 32-bit add
	function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	// saturating signed 32-bit add
	function automatic logic [31:0] sat_add_s32(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {a[31], a} + {b[31], b};
		if (s[32] != s[31])
			return s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		return s[31:0];
	endfunction

endpackage

// ===== design/psfbt_entry_upd.sv =====
//------------------------------------------------------------------------------
// psfbt_entry_upd: entry update unit
// Applies one operation step to a held entry: ticket add with ban, window
// refresh, or forget test. The sequencer calls it once per step.
//------------------------------------------------------------------------------
module psfbt_entry_upd (
	input  logic [1:0]            op,
	input  psfbt_pkg::entry_t     ent_in,
	input  logic [31:0]           delta,
	input  logic [31:0]           now,
	input  logic [15:0]           reset_time,
	input  logic [15:0]           max_tickets,
	input  logic [15:0]           ban_time,
	input  logic [15:0]           forget_time,
	output psfbt_pkg::entry_t     ent_out,
	output logic                  flag
);
	logic [31:0] tsum;
	logic [32:0] win;

	always_comb begin
		ent_out = ent_in;
		flag    = 1'b0;
		tsum    = psfbt_pkg::sat_add_s32(ent_in.tickets, delta);
		win     = '0;
		case (op)
			psfbt_pkg::OP_ADD: begin
				ent_out.tickets   = tsum;
				ent_out.last_seen = now;
				// signed compare against unsigned limit
				if (!tsum[31] && (tsum >= {16'd0, max_tickets})) begin
					flag = 1'b1;
					ent_out.ban_until = psfbt_pkg::sat_add32(ent_in.ban_until,
						psfbt_pkg::sat_add32(now, {16'd0, ban_time}));
					ent_out.tickets = '0;
					if (ent_in.bans != 16'hFFFF) ent_out.bans = ent_in.bans + 16'd1;
				end
			end
			psfbt_pkg::OP_REFRESH: begin
				win = {1'b0, ent_in.last_reset} + {17'd0, reset_time};
				if (win <= {1'b0, now}) begin
					ent_out.last_reset = now;
					ent_out.tickets    = '0;
				end
				if (ent_in.ban_until != 0 && ent_in.ban_until <= now) begin
					ent_out.ban_until = '0;
					ent_out.last_seen = now;
				end
			end
			psfbt_pkg::OP_FORGET: begin
				win  = {1'b0, ent_in.last_seen} + {17'd0, forget_time};
				flag = (ent_in.ban_until == 0) && (win <= {1'b0, now});
			end
			default: ;
		endcase
	end
endmodule

// ===== design/per_source_flood_ban_table.sv =====
//------------------------------------------------------------------------------
// per_source_flood_ban_table: per-source rate limiter with bans
//------------------------------------------------------------------------------
// Check, ticket and report items scan the address table one slot at a time
// (read, then compare) through a single memory read port; the scan sets the
// rate. A tick visits SWEEP_PER_TICK slots (read, wait, forget test for a
// live slot, refresh), then posts the result. in_stall is high while an item
// is in work and low while the sequencer is idle; a finished result waits in
// the output register, the next item may be taken meanwhile, and the
// sequencer holds its last step until the output register is free.
//------------------------------------------------------------------------------
module per_source_flood_ban_table #(
	parameter int TABLE_ENTRIES  = psfbt_pkg::TableEntriesDefault,
	parameter int SWEEP_PER_TICK = psfbt_pkg::SweepPerTickDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [31:0] peer_addr,
	input  logic [15:0] ticket_delta,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        allowed,
	output logic        entry_known,
	output logic        table_full,
	output logic        ban_started,
	output logic [15:0] ban_count,
	output logic [2:0]  entries_freed
);
	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int SW = $clog2(SWEEP_PER_TICK + 1);

	localparam logic [3:0] ST_IDLE = 4'd0, ST_SCAN = 4'd1, ST_SCANW = 4'd2,
		ST_RD = 4'd3, ST_RDW = 4'd4, ST_ADD = 4'd5, ST_REF = 4'd6,
		ST_WB = 4'd7, ST_OUT = 4'd8, ST_SWRD = 4'd9, ST_SWW = 4'd10,
		ST_SWCHK = 4'd11, ST_SWREF = 4'd12;

	// configuration registers
	logic [15:0] forget_q, reset_q, max_q, ban_q;
	logic        wr_en;
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			forget_q <= 16'd600;
			reset_q  <= 16'd10;
			max_q    <= 16'd100;
			ban_q    <= 16'd300;
		end else if (wr_en && paddr[1:0] == 2'b00) begin
			unique case (paddr[3:2])
				psfbt_pkg::REG_FORGET: forget_q <= pwdata[15:0];
				psfbt_pkg::REG_RESET:  reset_q  <= pwdata[15:0];
				psfbt_pkg::REG_MAX:    max_q    <= pwdata[15:0];
				psfbt_pkg::REG_BAN:    ban_q    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			psfbt_pkg::REG_FORGET: prdata[15:0] = forget_q;
			psfbt_pkg::REG_RESET:  prdata[15:0] = reset_q;
			psfbt_pkg::REG_MAX:    prdata[15:0] = max_q;
			psfbt_pkg::REG_BAN:    prdata[15:0] = ban_q;
			default: ;
		endcase
	end

	// entry memory with registered read, valid bits in flops
	psfbt_pkg::entry_t mem [TABLE_ENTRIES];
	psfbt_pkg::entry_t rd_q;
	logic [IW-1:0]     rd_idx, wr_idx;
	logic              mem_we;
	psfbt_pkg::entry_t wr_data;
	logic [TABLE_ENTRIES-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (mem_we) mem[wr_idx] <= wr_data;
		rd_q <= mem[rd_idx];
	end

	// sequencer state
	logic [3:0]      state_q;
	logic [1:0]      cmd_q;
	logic [31:0]     addr_q;
	logic [31:0]     delta_q;
	logic [31:0]     now_q;
	logic [IW-1:0]   sweep_q;
	logic [IW-1:0]   scan_q;
	logic [IW-1:0]   hit_q, free_q;
	logic            hit_found_q, free_found_q, new_q;
	logic [SW-1:0]   swcnt_q;
	logic [2:0]      freed_q;
	logic            banned_q;
	psfbt_pkg::entry_t ent_q;

	psfbt_pkg::entry_t upd_out;
	logic              upd_flag;
	logic [1:0]        upd_op;

	psfbt_entry_upd u_upd (
		.op(upd_op), .ent_in(ent_q), .delta(delta_q), .now(now_q),
		.reset_time(reset_q), .max_tickets(max_q), .ban_time(ban_q),
		.forget_time(forget_q), .ent_out(upd_out), .flag(upd_flag)
	);

	always_comb begin
		unique case (state_q)
			ST_ADD:   upd_op = psfbt_pkg::OP_ADD;
			ST_SWCHK: upd_op = psfbt_pkg::OP_FORGET;
			default:  upd_op = psfbt_pkg::OP_REFRESH;
		endcase
	end

	logic in_acc, out_acc;
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid && !out_stall;

	// scanned slot index is the scan counter
	logic [IW-1:0] scan_idx;
	assign scan_idx = scan_q;

	always_comb begin
		rd_idx = scan_idx;
		unique case (state_q)
			ST_RD:   rd_idx = hit_q;
			ST_SWRD: rd_idx = sweep_q;
			default: rd_idx = scan_idx;
		endcase
	end

	assign mem_we  = (state_q == ST_WB) || (state_q == ST_SWREF);
	assign wr_idx  = (state_q == ST_SWREF) ? sweep_q : hit_q;
	assign wr_data = (state_q == ST_SWREF) ? upd_out : ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			valid_q   <= '0;
			now_q     <= '0;
			sweep_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			// the last step reloads the result register itself
			if (out_acc && state_q != ST_OUT) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (in_acc) begin
					cmd_q        <= cmd;
					addr_q       <= peer_addr;
					delta_q      <= (cmd == psfbt_pkg::CMD_REPORT) ?
						{{16{ticket_delta[15]}}, ticket_delta} : 32'd1;
					scan_q       <= '0;
					hit_found_q  <= 1'b0;
					free_found_q <= 1'b0;
					new_q        <= 1'b0;
					banned_q     <= 1'b0;
					freed_q      <= '0;
					swcnt_q      <= '0;
					if (cmd == psfbt_pkg::CMD_TICK) begin
						now_q   <= psfbt_pkg::sat_add32(now_q, 32'd1);
						state_q <= ST_SWRD;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				// issue read of slot scan_idx
				ST_SCAN: state_q <= ST_SCANW;
				// compare registered read data
				ST_SCANW: begin
					if (valid_q[scan_idx] && rd_q.addr == addr_q && !hit_found_q) begin
						hit_found_q <= 1'b1;
						hit_q       <= scan_idx;
					end
					if (!valid_q[scan_idx] && !free_found_q) begin
						free_found_q <= 1'b1;
						free_q       <= scan_idx;
					end
					if (scan_q == IW'(TABLE_ENTRIES - 1)) state_q <= ST_RD;
					else begin
						scan_q  <= scan_q + 1'b1;
						state_q <= ST_SCAN;
					end
				end
				ST_RD: begin
					if (hit_found_q) state_q <= ST_RDW;
					else if (cmd_q != psfbt_pkg::CMD_REPORT && free_found_q) begin
						hit_q       <= free_q;
						new_q       <= 1'b1;
						hit_found_q <= 1'b1;
						valid_q[free_q] <= 1'b1;
						ent_q <= '{addr: addr_q, tickets: '0, last_seen: now_q,
							last_reset: now_q, ban_until: '0, bans: '0};
						state_q <= (cmd_q == psfbt_pkg::CMD_TICKET) ? ST_ADD : ST_REF;
					end else state_q <= ST_OUT;
				end
				ST_RDW: begin
					ent_q   <= rd_q;
					state_q <= (cmd_q == psfbt_pkg::CMD_CHECK) ? ST_REF : ST_ADD;
				end
				ST_ADD: begin
					ent_q    <= upd_out;
					banned_q <= upd_flag;
					state_q  <= (cmd_q == psfbt_pkg::CMD_REPORT) ? ST_WB : ST_REF;
				end
				ST_REF: begin
					ent_q   <= upd_out;
					state_q <= ST_WB;
				end
				ST_WB: state_q <= ST_OUT;
				// post the result once the output register is free
				ST_OUT: if (!out_valid || out_acc) begin
					out_valid     <= 1'b1;
					entry_known   <= hit_found_q;
					table_full    <= !hit_found_q && cmd_q != psfbt_pkg::CMD_REPORT &&
						cmd_q != psfbt_pkg::CMD_TICK;
					allowed       <= cmd_q != psfbt_pkg::CMD_TICK &&
						(!hit_found_q || ent_q.ban_until == 0);
					ban_started   <= banned_q;
					ban_count     <= hit_found_q ? ent_q.bans : 16'd0;
					entries_freed <= freed_q;
					state_q       <= ST_IDLE;
				end
				// sweep: read slot, test, refresh or free
				ST_SWRD: state_q <= ST_SWW;
				ST_SWW: begin
					ent_q   <= rd_q;
					state_q <= valid_q[sweep_q] ? ST_SWCHK : ST_SWREF;
				end
				ST_SWCHK: begin
					if (upd_flag) begin
						valid_q[sweep_q] <= 1'b0;
						freed_q <= freed_q + 3'd1;
					end
					state_q <= ST_SWREF;
				end
				ST_SWREF: begin
					// the refresh is written back for every swept slot; harmless for a slot that is not live
					sweep_q <= (sweep_q == IW'(TABLE_ENTRIES - 1)) ? '0 : sweep_q + 1'b1;
					if (swcnt_q == SW'(SWEEP_PER_TICK - 1)) begin
						state_q <= ST_OUT;
					end else begin
						swcnt_q <= swcnt_q + 1'b1;
						state_q <= ST_SWRD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== design/psfbt_checker.sv =====
//------------------------------------------------------------------------------
// psfbt_checker: port-level checks for the flood ban table
// Watches handshakes and result fields; bound to the top level.
//------------------------------------------------------------------------------
module psfbt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        allowed,
	input logic        entry_known,
	input logic        table_full,
	input logic        ban_started,
	input logic [15:0] ban_count,
	input logic [2:0]  entries_freed
);
	// held result stays put (valid and ban count)
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(ban_count))
		else $error("result changed while stalled");

	// a full table never reports a known entry and always allows the item
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && table_full |-> !entry_known && allowed)
		else $error("table full with known entry");

	// a ban start implies a known source with a ban counted
	a_ban: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ban_started |-> entry_known && ban_count != 0)
		else $error("ban start without entry");

	// an offered item stays offered while stalled
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid)
		else $error("input item withdrawn while stalled");

	// sweep counts stay within a tick's reach
	a_freed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entries_freed <= 3'd4)
		else $error("freed count out of range");
endmodule

bind per_source_flood_ban_table psfbt_checker u_psfbt_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .allowed(allowed),
	.entry_known(entry_known), .table_full(table_full),
	.ban_started(ban_started), .ban_count(ban_count),
	.entries_freed(entries_freed)
);

// ===== bench/per_source_flood_ban_table_test.sv =====
//------------------------------------------------------------------------------
// per_source_flood_ban_table_test: self-checking bench for the flood ban table
// Drives check, ticket, report and tick items with random gaps, mirrors the
// address table in a local predictor and compares every result field.
//------------------------------------------------------------------------------
module per_source_flood_ban_table_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int Slots       = 64;
	localparam int SweepStep   = 1;
	localparam int CycleLimit  = 2000000;
	localparam int SettleCycles = 100;

	typedef struct {
		logic [1:0]  cmd;
		logic [31:0] addr;
		logic [15:0] delta;
	} request_t;

	typedef struct {
		logic        allowed;
		logic        known;
		logic        full;
		logic        started;
		logic [15:0] bans;
		logic [2:0]  freed;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] cmd = '0;
	logic [31:0] peer_addr = '0;
	logic [15:0] ticket_delta = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic allowed, entry_known, table_full, ban_started;
	logic [15:0] ban_count;
	logic [2:0] entries_freed;

	per_source_flood_ban_table #(.TABLE_ENTRIES(Slots), .SWEEP_PER_TICK(SweepStep)) dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor copy of the table and registers
	logic [15:0] forget_q, window_q, limit_q, penalty_q;
	logic        tbl_valid [Slots];
	logic [31:0] tbl_addr [Slots];
	int          tbl_tickets [Slots];
	logic [31:0] tbl_seen [Slots];
	logic [31:0] tbl_reset [Slots];
	logic [31:0] tbl_ban_end [Slots];
	logic [15:0] tbl_bans [Slots];
	logic [31:0] clock_now;
	int          sweep_pos;

	request_t pending_items[$];
	verdict_t expected_verdicts[$];
	int accepted_items = 0;
	int mismatches = 0;
	int cycles = 0;
	logic [31:0] addr_pool [16];

	function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	// add tickets; returns 1 when the limit is hit and a ban starts
	function automatic logic charge(input int i, input int d);
		longint s;
		s = longint'(tbl_tickets[i]) + longint'(d);
		if (s > 64'sd2147483647) s = 64'sd2147483647;
		if (s < -64'sd2147483648) s = -64'sd2147483648;
		tbl_tickets[i] = int'(s);
		tbl_seen[i] = clock_now;
		if (longint'(tbl_tickets[i]) < longint'(limit_q)) return 1'b0;
		tbl_ban_end[i] = sat_sum(tbl_ban_end[i], sat_sum(clock_now, {16'd0, penalty_q}));
		tbl_tickets[i] = 0;
		if (tbl_bans[i] != 16'hFFFF) tbl_bans[i]++;
		return 1'b1;
	endfunction

	// window clear and ban expiry; returns 1 if not banned
	function automatic logic age_entry(input int i);
		if ({1'b0, tbl_reset[i]} + {17'd0, window_q} <= {1'b0, clock_now}) begin
			tbl_reset[i] = clock_now;
			tbl_tickets[i] = 0;
		end
		if (tbl_ban_end[i] != 0 && tbl_ban_end[i] <= clock_now) begin
			tbl_ban_end[i] = 0;
			tbl_seen[i] = clock_now;
		end
		return tbl_ban_end[i] == 0;
	endfunction

	function automatic int lookup(input logic [31:0] a);
		for (int i = 0; i < Slots; i++)
			if (tbl_valid[i] && tbl_addr[i] == a) return i;
		return -1;
	endfunction

	function automatic verdict_t flood_step(input request_t r);
		verdict_t v;
		int s;
		v = '{default: '0};
		if (r.cmd == psfbt_pkg::CMD_TICK) begin
			clock_now = sat_sum(clock_now, 32'd1);
			for (int k = 0; k < SweepStep; k++) begin
				if (tbl_valid[sweep_pos]) begin
					if (tbl_ban_end[sweep_pos] == 0 && {1'b0, tbl_seen[sweep_pos]} +
							{17'd0, forget_q} <= {1'b0, clock_now}) begin
						tbl_valid[sweep_pos] = 1'b0;
						v.freed++;
					end else
						void'(age_entry(sweep_pos));
				end
				sweep_pos = (sweep_pos + 1) % Slots;
			end
		end else if (r.cmd == psfbt_pkg::CMD_REPORT) begin
			s = lookup(r.addr);
			v.allowed = 1'b1;
			if (s >= 0) begin
				v.known = 1'b1;
				v.started = charge(s, int'($signed(r.delta)));
				v.allowed = tbl_ban_end[s] == 0;
				v.bans = tbl_bans[s];
			end
		end else begin
			s = lookup(r.addr);
			if (s < 0) begin
				for (int i = 0; i < Slots; i++)
					if (!tbl_valid[i]) begin
						s = i;
						break;
					end
				if (s >= 0) begin
					tbl_valid[s] = 1'b1; tbl_addr[s] = r.addr; tbl_tickets[s] = 0;
					tbl_seen[s] = clock_now; tbl_reset[s] = clock_now;
					tbl_ban_end[s] = 0; tbl_bans[s] = 0;
				end
			end
			if (s < 0) begin
				v.allowed = 1'b1;
				v.full = 1'b1;
			end else begin
				v.known = 1'b1;
				if (r.cmd == psfbt_pkg::CMD_TICKET) v.started = charge(s, 1);
				v.allowed = age_entry(s);
				v.bans = tbl_bans[s];
			end
		end
		return v;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 60) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// item driver: holds payload until accepted
	int gap_left = 0;
	request_t cur;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_verdicts.insert(expected_verdicts.size(), flood_step(cur));
				accepted_items++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					cur = pending_items.pop_front();
					cmd <= cur.cmd;
					peer_addr <= cur.addr;
					ticket_delta <= cur.delta;
					in_valid <= 1'b1;
					// the second hundred items of every four hundred run back to back
					gap_left = ((accepted_items / 100) % 4 == 1) ? 0 : pick_gap();
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// one long receiver hold so the block backs up into its input
	int hold_left = 0;
	logic held_once = 1'b0;
	always @(posedge clk) begin
		if (!held_once && accepted_items >= 300) begin
			held_once <= 1'b1;
			hold_left <= 2000;
		end else if (hold_left > 0)
			hold_left <= hold_left - 1;
	end

	// receiver stall pattern
	int stall_left = 0;
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= hold_left > 1;
			if ((accepted_items / 100) % 4 != 1 && $urandom_range(0, 3) == 0)
				stall_left = pick_gap();
		end
	end

	// result checker
	always @(posedge clk) begin
		verdict_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_verdicts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
			end else begin
				e = expected_verdicts.pop_front();
				if (e.allowed !== allowed || e.known !== entry_known || e.full !== table_full ||
						e.started !== ban_started || e.bans !== ban_count ||
						e.freed !== entries_freed) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch cycle %0d exp a%b k%b f%b s%b b%0d fr%0d got a%b k%b f%b s%b b%0d fr%0d",
							cycles, e.allowed, e.known, e.full, e.started, e.bans, e.freed,
							allowed, entry_known, table_full, ban_started, ban_count,
							entries_freed);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= {16'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			psfbt_pkg::REG_FORGET: forget_q = val;
			psfbt_pkg::REG_RESET:  window_q = val;
			psfbt_pkg::REG_MAX:    limit_q = val;
			default:               penalty_q = val;
		endcase
	endtask

	task automatic set_limits(input logic [15:0] f, input logic [15:0] w,
			input logic [15:0] m, input logic [15:0] b);
		write_reg(psfbt_pkg::REG_FORGET, f);
		write_reg(psfbt_pkg::REG_RESET, w);
		write_reg(psfbt_pkg::REG_MAX, m);
		write_reg(psfbt_pkg::REG_BAN, b);
	endtask

	task automatic push(input logic [1:0] c, input logic [31:0] a, input logic [15:0] d);
		request_t r;
		r.cmd = c; r.addr = a; r.delta = d;
		pending_items.insert(pending_items.size(), r);
	endtask

	task automatic drain();
		while (pending_items.size() > 0 || in_valid || expected_verdicts.size() > 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// random mix: pooled addresses for hits, fresh ones to fill the table
	task automatic random_items(input int n, input int fresh_pct);
		logic [1:0] c;
		logic [31:0] a;
		logic [15:0] d;
		for (int k = 0; k < n; k++) begin
			c = 2'($urandom_range(0, 3));
			a = ($urandom_range(0, 99) < fresh_pct) ? $urandom() : addr_pool[$urandom_range(0, 15)];
			d = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($signed($urandom_range(0, 14)) - 3);
			push(c, a, d);
		end
	endtask

	initial begin
		forget_q = 16'd600; window_q = 16'd10; limit_q = 16'd100; penalty_q = 16'd300;
		for (int i = 0; i < Slots; i++) begin
			tbl_valid[i] = 1'b0; tbl_addr[i] = '0; tbl_tickets[i] = 0; tbl_seen[i] = '0;
			tbl_reset[i] = '0; tbl_ban_end[i] = '0; tbl_bans[i] = '0;
		end
		clock_now = '0;
		sweep_pos = 0;
		addr_pool[0] = 32'h0000_0000;
		addr_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < 16; i++) addr_pool[i] = $urandom();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, each command, unknown report, ban, expiry
		push(psfbt_pkg::CMD_REPORT, 32'hFFFF_FFFF, 16'sd5);
		push(psfbt_pkg::CMD_CHECK, 32'h0000_0000, 16'h0000);
		push(psfbt_pkg::CMD_CHECK, 32'hFFFF_FFFF, 16'hFFFF);
		push(psfbt_pkg::CMD_TICKET, 32'hFFFF_FFFF, 16'h0000);
		push(psfbt_pkg::CMD_REPORT, 32'h0000_0000, 16'h7FFF);
		push(psfbt_pkg::CMD_REPORT, 32'h0000_0000, 16'h8000);
		push(psfbt_pkg::CMD_REPORT, 32'hFFFF_FFFF, 16'd98);
		push(psfbt_pkg::CMD_REPORT, 32'hFFFF_FFFF, 16'd200);
		push(psfbt_pkg::CMD_CHECK, 32'hFFFF_FFFF, 16'h0000);
		push(psfbt_pkg::CMD_TICK, 32'h0000_0000, 16'h0000);
		push(psfbt_pkg::CMD_TICK, 32'hFFFF_FFFF, 16'hFFFF);
		drain();
		set_limits(16'd3, 16'd0, 16'd1, 16'd0);
		push(psfbt_pkg::CMD_TICKET, 32'h1234_5678, 16'h0000);
		push(psfbt_pkg::CMD_CHECK, 32'h1234_5678, 16'h0000);
		push(psfbt_pkg::CMD_REPORT, 32'h1234_5678, 16'hFFFF);
		for (int k = 0; k < 8; k++) push(psfbt_pkg::CMD_TICK, 32'h0, 16'h0);
		push(psfbt_pkg::CMD_CHECK, 32'h1234_5678, 16'h0000);
		random_items(230, 10);
		drain();
		set_limits(16'd0, 16'd0, 16'd1, 16'd0);
		random_items(200, 5);
		drain();
		// long memories: table fills and reports table full
		set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		for (int k = 0; k < 70; k++) push(psfbt_pkg::CMD_CHECK, $urandom(), 16'h0);
		random_items(160, 20);
		drain();
		set_limits(16'd40, 16'd5, 16'd4, 16'd20);
		random_items(270, 3);
		drain();

		if (mismatches == 0 && expected_verdicts.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
